FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the vertex transform RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk_i, off during reset.
`define VT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition this cycle implies consequence next cycle.
`define VT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/vt_pkg.sv
// Package for the vertex transform block: field widths, opcodes, control structs.
// No dependencies.
`default_nettype none

package vt_pkg;

  localparam int FIELD_BITS = 32;
  localparam int IDX_BITS   = 2;
  localparam int MAX_DIM    = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   row;
    logic [IDX_BITS-1:0]   col;
    logic [FIELD_BITS-1:0] value;
  } vt_load_t;

  typedef struct packed {
    logic en;
    logic valid;
  } vt_stage_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vt_matrix_regs.sv
// Matrix element storage, cleared by reset, written one element per load beat.
// Depends on vt_pkg.
`default_nettype none

module vt_matrix_regs #(
  parameter int DIM       = 4,
  parameter int WORD_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire vt_pkg::vt_load_t            load_i,
  output logic signed [WORD_BITS-1:0]      mat_o [DIM][DIM]
);
  import vt_pkg::*;

  logic signed [WORD_BITS-1:0] mat_q [DIM][DIM];

  for (genvar r = 0; r < DIM; r++) begin : g_row
    for (genvar c = 0; c < DIM; c++) begin : g_col
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mat_q[r][c] <= '0;
        end else if (load_i.en && load_i.row == IDX_BITS'(r)
                     && load_i.col == IDX_BITS'(c)) begin
          mat_q[r][c] <= load_i.value[WORD_BITS-1:0];
        end
      end
      assign mat_o[r][c] = mat_q[r][c];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vt_product_stage.sv
// Multiply stage: all element-by-component products, registered.
// Depends on vt_pkg.
`default_nettype none

module vt_product_stage #(
  parameter int DIM       = 4,
  parameter int WORD_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vt_pkg::vt_stage_t             ctl_i,
  input  wire logic signed [WORD_BITS-1:0]   vec_i  [DIM],
  input  wire logic signed [WORD_BITS-1:0]   mat_i  [DIM][DIM],
  output logic signed [2*WORD_BITS-1:0]      prod_o [DIM][DIM],
  output logic                               valid_o
);
  import vt_pkg::*;

  localparam int PROD_W = 2 * WORD_BITS;

  logic                     valid_q;
  logic signed [PROD_W-1:0] prod_q [DIM][DIM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_row
    for (genvar j = 0; j < DIM; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (ctl_i.en) begin
          prod_q[i][j] <= PROD_W'(mat_i[i][j]) * PROD_W'(vec_i[i]);
        end
      end
      assign prod_o[i][j] = prod_q[i][j];
    end
  end

  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vt_reduce_sat.sv
// Column sums, floor shift by the fraction width, saturation; result register.
// Depends on vt_pkg.
`default_nettype none

module vt_reduce_sat #(
  parameter int DIM       = 4,
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire vt_pkg::vt_stage_t                  ctl_i,
  input  wire logic signed [2*WORD_BITS-1:0]      prod_i [DIM][DIM],
  output logic signed [vt_pkg::FIELD_BITS-1:0]    res_o  [vt_pkg::MAX_DIM],
  output logic                                    ovf_o,
  output logic                                    valid_o
);
  import vt_pkg::*;

  localparam int SUM_W = 2 * WORD_BITS + $clog2(DIM);
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic                         valid_q;
  logic                         ovf_q, ovf_d;
  logic signed [FIELD_BITS-1:0] res_q [MAX_DIM];
  logic signed [FIELD_BITS-1:0] res_d [MAX_DIM];

  always_comb begin : p_reduce
    logic signed [SUM_W-1:0]     acc;
    logic signed [SUM_W-1:0]     shifted;
    logic signed [WORD_BITS-1:0] word;
    ovf_d   = 1'b0;
    acc     = '0;
    shifted = '0;
    word    = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      res_d[j] = '0;
    end
    for (int j = 0; j < DIM; j++) begin
      acc = '0;
      for (int i = 0; i < DIM; i++) begin
        acc = acc + SUM_W'(prod_i[i][j]);
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > SUM_W'(WMAX)) begin
        word  = WMAX;
        ovf_d = 1'b1;
      end else if (shifted < SUM_W'(WMIN)) begin
        word  = WMIN;
        ovf_d = 1'b1;
      end else begin
        word = shifted[WORD_BITS-1:0];
      end
      res_d[j] = FIELD_BITS'(word);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      ovf_q <= ovf_d;
      for (int j = 0; j < MAX_DIM; j++) begin
        res_q[j] <= res_d[j];
      end
    end
  end

  assign res_o   = res_q;
  assign ovf_o   = ovf_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_transform_4x4.sv
// Vertex transform: out[j] = sum_i M[i][j] * v[i], Q fixed point, saturated.
// The result passes the input, product and result registers, in that order.
// Throughput: one beat per cycle unless stalled; stages stall only if the next is full.
// Load beats write the matrix at the accepting edge and give no result.
// Reset clears the matrix and all stage valids; no clearing pass.
// Depends on vt_pkg, vt_matrix_regs, vt_product_stage, vt_reduce_sat, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vertex_transform_4x4 #(
  parameter int DIM       = 4,
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  operation_i,
  input  wire logic [vt_pkg::IDX_BITS-1:0]           row_index_i,
  input  wire logic [vt_pkg::IDX_BITS-1:0]           col_index_i,
  input  wire logic signed [vt_pkg::FIELD_BITS-1:0]  element_value_i,
  input  wire logic signed [vt_pkg::FIELD_BITS-1:0]  vec_x_i,
  input  wire logic signed [vt_pkg::FIELD_BITS-1:0]  vec_y_i,
  input  wire logic signed [vt_pkg::FIELD_BITS-1:0]  vec_z_i,
  input  wire logic signed [vt_pkg::FIELD_BITS-1:0]  vec_w_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic signed [vt_pkg::FIELD_BITS-1:0]       out_x_o,
  output logic signed [vt_pkg::FIELD_BITS-1:0]       out_y_o,
  output logic signed [vt_pkg::FIELD_BITS-1:0]       out_z_o,
  output logic signed [vt_pkg::FIELD_BITS-1:0]       out_w_o,
  output logic                                       overflow_o
);
  import vt_pkg::*;

  logic                         accept;
  logic                         en_out, en_prod, en_in;
  logic                         s1_valid_q;
  logic                         s2_valid;
  logic signed [WORD_BITS-1:0]  vec_all [MAX_DIM];
  logic signed [WORD_BITS-1:0]  vec_q   [DIM];
  logic signed [WORD_BITS-1:0]  mat     [DIM][DIM];
  logic signed [2*WORD_BITS-1:0] prod   [DIM][DIM];
  logic signed [FIELD_BITS-1:0] res     [MAX_DIM];
  vt_load_t                     load;
  vt_stage_t                    prod_ctl, res_ctl;

  assign en_out     = !out_valid_o || out_ready_i;
  assign en_prod    = !s2_valid || en_out;
  assign en_in      = !s1_valid_q || en_prod;
  assign in_ready_o = en_in;
  assign accept     = in_valid_i && in_ready_o;

  assign load.en    = accept && (operation_i == OP_LOAD);
  assign load.row   = row_index_i;
  assign load.col   = col_index_i;
  assign load.value = element_value_i;

  assign vec_all[0] = vec_x_i[WORD_BITS-1:0];
  assign vec_all[1] = vec_y_i[WORD_BITS-1:0];
  assign vec_all[2] = vec_z_i[WORD_BITS-1:0];
  assign vec_all[3] = vec_w_i[WORD_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_in) begin
      s1_valid_q <= accept && (operation_i == OP_XFORM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (operation_i == OP_XFORM)) begin
      for (int i = 0; i < DIM; i++) begin
        vec_q[i] <= vec_all[i];
      end
    end
  end

  vt_matrix_regs #(
    .DIM       (DIM),
    .WORD_BITS (WORD_BITS)
  ) u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .mat_o  (mat)
  );

  assign prod_ctl.en    = en_prod;
  assign prod_ctl.valid = s1_valid_q;

  vt_product_stage #(
    .DIM       (DIM),
    .WORD_BITS (WORD_BITS)
  ) u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (prod_ctl),
    .vec_i   (vec_q),
    .mat_i   (mat),
    .prod_o  (prod),
    .valid_o (s2_valid)
  );

  assign res_ctl.en    = en_out;
  assign res_ctl.valid = s2_valid;

  vt_reduce_sat #(
    .DIM       (DIM),
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (res_ctl),
    .prod_i  (prod),
    .res_o   (res),
    .ovf_o   (overflow_o),
    .valid_o (out_valid_o)
  );

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];
  assign out_w_o = res[3];

  `VT_ASSERT(a_stall_only_when_full, !in_ready_o |-> s1_valid_q, "input stalled with empty stage")
  `VT_ASSERT_NEXT(a_load_no_item, load.en, !s1_valid_q, "load beat entered the pipeline")
  `VT_ASSERT_NEXT(a_xform_enters, accept && (operation_i == OP_XFORM), s1_valid_q, "transform beat lost")

endmodule

`default_nettype wire
